>>> sv/ispc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ispc_pkg: shared types and constants
// Widths, register indexes and the lane control struct of the
// inverse-square potential cost block.
// ----------------------------------------------------------------------------
package ispc_pkg;

    localparam int COORD_W   = 16;
    localparam int NUM_COORD = 4;
    localparam int SRC_W     = COORD_W * NUM_COORD;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 32;
    localparam int D2_W      = 34;
    localparam int TERM_W    = 18;
    localparam int TOTAL_W   = 21;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 3;

    // Cap of one term, 1000.0 in unsigned Q.8.
    localparam logic [TERM_W-1:0] CAP_TERM = 18'd256000;

    // Below this squared distance the reciprocal of 2^24 exceeds the cap.
    localparam logic [D2_W-1:0] CAP_D2_LIMIT = 34'd66;

    // Above the cap limit the quotient has at most 18 bits, so the
    // divider starts with the top seven dividend bits (2^24 >> 18).
    localparam logic [STEP_W-1:0] DIV_STEPS = 5'd18;
    localparam logic [D2_W-1:0]   REM_INIT  = 34'd64;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE  = 3'd1;

    typedef logic [TERM_W-1:0]  term_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [SRC_W-1:0]   source_t;

    typedef struct packed {
        logic       clear;
        logic       mul_en;
        logic       acc_en;
        logic       div_init;
        logic       div_step;
        logic [1:0] dim;
    } lane_ctrl_t;

endpackage
`default_nettype wire

>>> sv/ispc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ispc_lane: one source lane
// Accumulates the squared distance one coordinate per cycle, then runs a
// restoring division of 2^24 by it, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ispc_lane
(
    input  wire logic                clk,
    input  wire ispc_pkg::lane_ctrl_t ctrl,
    input  wire logic [15:0]         query_coord,
    input  wire ispc_pkg::source_t   source,
    output ispc_pkg::term_t          term
);
    import ispc_pkg::*;

    logic signed [COORD_W-1:0] src_coord;
    logic signed [DIFF_W-1:0]  diff;
    logic [PROD_W-1:0]         prod_reg;
    logic [D2_W-1:0]           d2_reg;
    logic [D2_W-1:0]           rem_reg;
    logic [TERM_W-1:0]         quo_reg;
    logic                      cap_reg;
    logic [D2_W:0]             rem_shift;
    logic                      q_bit;

    always_comb
    begin
        case (ctrl.dim)
            2'd0:    src_coord = source[15:0];
            2'd1:    src_coord = source[31:16];
            2'd2:    src_coord = source[47:32];
            2'd3:    src_coord = source[63:48];
            default: src_coord = source[15:0];
        endcase
    end

    assign diff      = $signed({query_coord[15], query_coord}) -
                       $signed({src_coord[15], src_coord});
    assign rem_shift = {rem_reg, 1'b0};
    assign q_bit     = (rem_shift >= {1'b0, d2_reg});

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(diff * diff);
        end
        if (ctrl.clear)
        begin
            d2_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            d2_reg <= d2_reg + D2_W'(prod_reg);
        end
        if (ctrl.div_init)
        begin
            rem_reg <= REM_INIT;
            quo_reg <= '0;
            cap_reg <= (d2_reg < CAP_D2_LIMIT);
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= q_bit ? D2_W'(rem_shift - {1'b0, d2_reg}) : D2_W'(rem_shift);
            quo_reg <= {quo_reg[TERM_W-2:0], q_bit};
        end
    end

    assign term = cap_reg ? CAP_TERM : quo_reg;

    // The partial remainder stays below the divisor through every step.
    a_rem_below_divisor: assert property (@(posedge clk)
        ctrl.div_step && !cap_reg |-> rem_reg < d2_reg)
        else $error("lane remainder not below divisor");

endmodule
`default_nettype wire

>>> sv/ispc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ispc_merge: term accumulator
// Loads the lane terms into a shift line and adds one per cycle.
// ----------------------------------------------------------------------------
module ispc_merge
#(
    parameter int MAX_SOURCES = 6
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire ispc_pkg::term_t     terms [MAX_SOURCES],
    input  wire logic [MAX_SOURCES-1:0] active,
    output logic                     done,
    output ispc_pkg::total_t         total
);
    import ispc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SOURCES + 1);

    term_t             sh_reg [MAX_SOURCES];
    total_t            acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              done_reg;
    logic              done_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (load)
        begin
            cnt_next = CNT_W'(MAX_SOURCES);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg <= '0;
            for (int i = 0; i < MAX_SOURCES; i++)
            begin
                sh_reg[i] <= active[i] ? terms[i] : '0;
            end
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_reg + TOTAL_W'(sh_reg[0]);
            for (int i = 0; i < MAX_SOURCES - 1; i++)
            begin
                sh_reg[i] <= sh_reg[i+1];
            end
            sh_reg[MAX_SOURCES-1] <= '0;
        end
    end

    assign done  = done_reg;
    assign total = acc_reg;

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> cnt_reg == CNT_W'(MAX_SOURCES))
        else $error("merge count not loaded");

    a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> cnt_reg == '0 && $past(cnt_reg) == CNT_W'(1))
        else $error("merge done outside the last step");

    a_no_early_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> cnt_reg == '0)
        else $error("merge loaded while busy");

endmodule
`default_nettype wire

>>> sv/inverse_square_potential_cost.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_square_potential_cost: top level
// Sums capped inverse-square terms of a query point against up to
// MAX_SOURCES configured point sources, one lane per source.
// ----------------------------------------------------------------------------
//  Channel   Signals                           Carries
//  s_        s_tvalid s_tready s_tdata[63:0]   coord_0 .. coord_3 query
//  m_        m_tvalid m_tready m_tdata[23:0]   total_cost
//  cfg_      cfg_we cfg_index cfg_wdata        source_count, source_0..5
//
// From acceptance, an item passes through the distance multiplier, the
// divider in each lane, the serial merge adder and the load of the output
// register; the sequencer then returns to idle, and only there is the
// next item accepted. A total that waits in the output register holds the
// next one back, and the input stays closed meanwhile.
// Reset clears the configuration registers, the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module inverse_square_potential_cost
#(
    parameter int DIMS        = 2,
    parameter int MAX_SOURCES = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,    // coord_0, coord_1, coord_2, coord_3
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // total_cost, zero fill
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);
    import ispc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIST  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_MERGE = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    localparam total_t MAX_TOTAL = TOTAL_W'(MAX_SOURCES) * TOTAL_W'(CAP_TERM);

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [2:0]          count_reg;
    source_t             src_reg [MAX_SOURCES];
    logic [COORD_W-1:0]  query_reg [NUM_COORD];
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    total_t              total_reg;
    logic                accept;
    lane_ctrl_t          ctrl;
    term_t               terms [MAX_SOURCES];
    logic [MAX_SOURCES-1:0] active;
    logic                merge_load;
    logic                merge_done;
    total_t              merge_total;
    logic                out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_HOLD) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        merge_load    = 1'b0;
        ctrl          = '0;
        ctrl.dim      = step_reg[1:0];
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.clear = accept;
                if (accept)
                begin
                    state_next = ST_DIST;
                    step_next  = '0;
                end
            end
            ST_DIST:
            begin
                // Multiply one coordinate per cycle; the sum trails through the product register.
                ctrl.mul_en = (step_reg < STEP_W'(DIMS));
                ctrl.acc_en = (step_reg != '0);
                if (step_reg == STEP_W'(DIMS))
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                ctrl.div_init = (step_reg == '0);
                ctrl.div_step = (step_reg != '0);
                if (step_reg == DIV_STEPS)
                begin
                    state_next = ST_MERGE;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MERGE:
            begin
                merge_load = (step_reg == '0);
                step_next  = STEP_W'(1);
                if (merge_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
            for (int i = 0; i < MAX_SOURCES; i++)
            begin
                src_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we && cfg_index == REG_SOURCE_COUNT)
            begin
                count_reg <= cfg_wdata[2:0];
            end
            for (int i = 0; i < MAX_SOURCES; i++)
            begin
                if (cfg_we && cfg_index == REG_SOURCE_BASE + CFG_IDX_W'(i))
                begin
                    src_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < NUM_COORD; k++)
            begin
                query_reg[k] <= s_tdata[k*COORD_W +: COORD_W];
            end
        end
        if (out_load)
        begin
            total_reg <= merge_total;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SOURCES; g++)
        begin : g_lane
            // A count above MAX_SOURCES simply enables every lane.
            assign active[g] = (count_reg > 3'(g));

            ispc_lane u_lane
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .query_coord (query_reg[step_reg[1:0]]),
                .source      (src_reg[g]),
                .term        (terms[g])
            );
        end
    endgenerate

    ispc_merge #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_merge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (merge_load),
        .terms  (terms),
        .active (active),
        .done   (merge_done),
        .total  (merge_total)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, total_reg};

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DIST && step_reg == '0)
        else $error("accepted item did not start the distance phase");

    a_done_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
        merge_done |-> state_reg == ST_MERGE)
        else $error("merge finished outside the merge phase");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> total_reg <= MAX_TOTAL)
        else $error("total above the largest possible sum");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(total_reg))
        else $error("waiting total was overwritten");

endmodule
`default_nettype wire

>>> bench/ispc_cost_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ispc_cost_checker: result checker for the inverse-square potential cost
// Shadows the configuration writes, predicts the total of every accepted
// query item and compares it with the totals leaving the block, in order.
// ----------------------------------------------------------------------------
module ispc_cost_checker
#(
    parameter int DIMS        = 2,
    parameter int MAX_SOURCES = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,    // coord_0, coord_1, coord_2, coord_3
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,    // total_cost, zero fill
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    output int               fail_count,
    output int               outstanding,
    output int               totals_checked
);
    import ispc_pkg::*;

    localparam int NUM_SOURCE_REGS = 6;

    typedef logic signed [COORD_W-1:0] coord_t;

    logic [2:0] count_shadow;
    source_t    source_shadow [NUM_SOURCE_REGS];
    total_t     pending_totals [$];
    int         fails;
    int         compared;

    // Sum of min(2^24 / d2, cap) over the sources in use.
    function automatic total_t predict_total(logic [63:0] query);
        longint d2;
        longint delta;
        longint term;
        coord_t q_coord;
        coord_t p_coord;
        int     in_use;
        total_t sum;
        in_use = (count_shadow > MAX_SOURCES) ? MAX_SOURCES : count_shadow;
        sum = '0;
        for (int s = 0; s < in_use; s++)
        begin
            d2 = 0;
            for (int k = 0; k < DIMS && k < NUM_COORD; k++)
            begin
                q_coord = query[k*COORD_W +: COORD_W];
                p_coord = source_shadow[s][k*COORD_W +: COORD_W];
                delta = longint'(q_coord) - longint'(p_coord);
                d2 += delta * delta;
            end
            if (d2 == 0)
                term = CAP_TERM;
            else
            begin
                term = (longint'(1) <<< 24) / d2;
                if (term > CAP_TERM)
                    term = CAP_TERM;
            end
            sum += total_t'(term);
        end
        return sum;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        total_t expected;
        if (!rst_n)
        begin
            count_shadow = '0;
            for (int i = 0; i < NUM_SOURCE_REGS; i++)
                source_shadow[i] = '0;
            pending_totals.delete();
            fails = 0;
            compared = 0;
            fail_count <= 0;
            outstanding <= 0;
            totals_checked <= 0;
        end
        else
        begin
            // The query sees the configuration from before any write at this edge.
            if (s_tvalid && s_tready)
                pending_totals.insert(pending_totals.size(), predict_total(s_tdata));

            if (cfg_we)
            begin
                if (cfg_index == REG_SOURCE_COUNT)
                    count_shadow = cfg_wdata[2:0];
                else if (cfg_index - REG_SOURCE_BASE < NUM_SOURCE_REGS)
                    source_shadow[cfg_index - REG_SOURCE_BASE] = cfg_wdata;
            end

            if (m_tvalid && m_tready)
            begin
                if (pending_totals.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected total: expected none, actual %0d (0x%06h)",
                             $time, m_tdata[TOTAL_W-1:0], m_tdata);
                end
                else
                begin
                    expected = pending_totals.pop_front();
                    compared++;
                    if (m_tdata !== {{(24-TOTAL_W){1'b0}}, expected})
                    begin
                        fails++;
                        $display("%0t: total_cost mismatch: expected %0d, actual %0d (0x%06h)",
                                 $time, expected, m_tdata[TOTAL_W-1:0], m_tdata);
                    end
                end
            end

            fail_count <= fails;
            outstanding <= pending_totals.size();
            totals_checked <= compared;
        end
    end

endmodule

>>> bench/tb_inverse_square_potential_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inverse_square_potential_cost: testbench top
// Drives query items in random bursts against a range of source settings,
// stalls the result side on its own pattern and reports the verdict of the
// checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_inverse_square_potential_cost;
    import ispc_pkg::*;

    localparam int DIMS            = 2;
    localparam int MAX_SOURCES     = 6;
    localparam int LATENCY         = DIMS + MAX_SOURCES + 24 + 8;
    localparam int IDLE_LIMIT      = 4000;
    localparam int LONG_HOLD       = 400;
    localparam int PHASE_ITEMS     = 72;
    localparam int NUM_PHASES      = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = REG_SOURCE_BASE + 3'd6;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // coord_0, coord_1, coord_2, coord_3
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // total_cost, zero fill
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;

    int          fail_count;
    int          outstanding;
    int          totals_checked;
    int          hold_requests;
    int          idle_cycles;
    int          queries_sent;
    int          settings_used;
    source_t     src_cfg [6];

    inverse_square_potential_cost #(
        .DIMS        (DIMS),
        .MAX_SOURCES (MAX_SOURCES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ispc_cost_checker #(
        .DIMS        (DIMS),
        .MAX_SOURCES (MAX_SOURCES)
    ) cost_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .totals_checked (totals_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Ends the run when nothing has moved on either channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("inverse_square_potential_cost test failed");
            $finish;
        end
    end

    // Result side: stretches of steady, random or heavy stalling, plus a long
    // hold-off whenever the stimulus asks for one.
    initial
    begin
        int mode;
        int stretch;
        int holds_served;
        mode = 0;
        stretch = 0;
        holds_served = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode = $urandom_range(0, 3);
                    stretch = $urandom_range(10, 80);
                end
                stretch--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_query(input logic [63:0] query);
        s_tvalid <= 1'b1;
        s_tdata <= query;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        queries_sent++;
    endtask

    // Stops offering items and waits until every expected total has arrived,
    // then lets the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Mostly queries near one of the sources, at distances from zero up to
    // nearly the point where the term rounds to zero; some anywhere.
    function automatic logic [63:0] random_query();
        logic [63:0] query;
        int          s;
        int          span;
        query = {$urandom, $urandom};
        case ($urandom_range(0, 8))
            0:       span = 0;
            1:       span = 3;
            2:       span = 8;
            3:       span = 40;
            4:       span = 300;
            5:       span = 2000;
            default: span = -1;
        endcase
        if (span >= 0)
        begin
            s = $urandom_range(0, 5);
            for (int k = 0; k < DIMS; k++)
                query[k*COORD_W +: COORD_W] = src_cfg[s][k*COORD_W +: COORD_W]
                    + 16'($urandom_range(0, 2 * span)) - 16'(span);
        end
        return query;
    endfunction

    initial
    begin
        int          counts [NUM_PHASES];
        int          spread;
        int          in_phase;
        int          burst;
        logic [63:0] value;
        logic [63:0] center;

        counts = '{6, 1, 3, 7, 2, 5, 4, 6};
        hold_requests <= 0;
        queries_sent = 0;
        settings_used = 1;
        for (int i = 0; i < 6; i++)
            src_cfg[i] = '0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset configuration no source is in use.
        send_query(64'hFFFF_FFFF_FFFF_FFFF);
        send_query(64'h0);
        drain();

        // One source at the origin: zero distance, distances under the cap
        // limit and around it, and the coordinate extremes.
        write_reg(REG_SOURCE_COUNT, 64'd1);
        write_reg(REG_SOURCE_BASE, 64'h0);
        settings_used++;
        send_query({16'h1234, 16'hABCD, 16'h0000, 16'h0000});
        send_query({32'h0, 16'h0000, 16'h0001});
        send_query({32'h0, 16'h0001, 16'h0008});
        send_query({32'hFFFF_FFFF, 16'h0002, 16'hFFF8});
        send_query({32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF});
        send_query({32'h0, 16'h8000, 16'h8000});
        send_query({32'h5555_AAAA, 16'h8000, 16'h7FFF});
        drain();
        write_reg(REG_SOURCE_BASE, {32'hDEAD_BEEF, 16'h8000, 16'h8000});
        settings_used++;
        send_query({32'h0, 16'h7FFF, 16'h7FFF});
        drain();

        // A count of seven with upper bits set acts as six sources, all at the
        // same point; the write past the last register must change nothing.
        write_reg(REG_SOURCE_COUNT, 64'hA5A5_0000_0000_000F);
        for (int i = 0; i < 6; i++)
        begin
            src_cfg[i] = {$urandom, 16'h0100, 16'h0100};
            write_reg(REG_SOURCE_BASE + 3'(i), src_cfg[i]);
        end
        write_reg(REG_PAST_LAST, {$urandom, $urandom});
        settings_used++;
        send_query({32'hCAFE_F00D, 16'h0100, 16'h0100});
        send_query({32'h0, 16'h0100, 16'h0110});
        send_query({32'h0, 16'h0180, 16'h0100});
        drain();

        // Count of two; the sources beyond it still sit on the query point.
        write_reg(REG_SOURCE_COUNT, 64'hFFFF_FFFF_FFFF_FFFA);
        write_reg(REG_SOURCE_BASE, 64'h0);
        write_reg(REG_SOURCE_BASE + 3'd1, {32'h0, 16'h0000, 16'h0010});
        settings_used++;
        send_query({32'h0, 16'h0100, 16'h0100});
        send_query({32'h0, 16'h0000, 16'h0000});
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            value = {$urandom, $urandom};
            value[2:0] = counts[phase][2:0];
            write_reg(REG_SOURCE_COUNT, value);
            center = {$urandom, $urandom};
            spread = (phase % 2 == 0) ? 150 : 30;
            for (int i = 0; i < 6; i++)
            begin
                src_cfg[i] = {$urandom, $urandom};
                if (phase != 6)
                    for (int k = 0; k < NUM_COORD; k++)
                        src_cfg[i][k*COORD_W +: COORD_W] = center[k*COORD_W +: COORD_W]
                            + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
                write_reg(REG_SOURCE_BASE + 3'(i), src_cfg[i]);
            end
            settings_used++;

            in_phase = 0;
            while (in_phase < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && in_phase < PHASE_ITEMS; b++)
                begin
                    send_query(random_query());
                    in_phase++;
                    // The sender keeps offering while the output is held off.
                    if (phase == 3 && in_phase == 20)
                        hold_requests <= hold_requests + 1;
                    if (phase == 5 && in_phase == 36)
                        drain();
                end
                // Phase two streams without any gap on the input side.
                if (phase != 2 && $urandom_range(0, 9) < 6)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            drain();
        end

        $display("Sent %0d queries over %0d source settings, counts 0 to 7 included.",
                 queries_sent, settings_used);
        $display("Compared %0d totals under bursty input and a stalling output.",
                 totals_checked);
        if (fail_count == 0 && outstanding == 0)
            $display("inverse_square_potential_cost test passed");
        else
            $display("inverse_square_potential_cost test failed");
        $finish;
    end

endmodule
